@@ hw/rtl/phcgb_pkg.sv @@
// shared types, constants and register map of the point height-class grid binner
// no dependencies; the design files that use these refer to them by scoped name, the testbench imports them
`timescale 1ns / 1ps
`default_nettype none

package phcgb_pkg;

  // grid geometry
  localparam int GRID_ROWS = 64;
  localparam int GRID_COLS = 64;
  localparam int CELL_MM   = 100;
  localparam int CELLS     = GRID_ROWS * GRID_COLS;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int ROW_W     = $clog2(GRID_ROWS);
  localparam int COL_W     = $clog2(GRID_COLS);
  localparam int IDX_W     = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int COL_SPAN  = GRID_COLS * CELL_MM;
  localparam int ROW_SPAN  = GRID_ROWS * CELL_MM;

  // field widths
  localparam int COORD_W = 16;
  localparam int RDIDX_W = 6;
  localparam int CELL_W  = 4;
  // offset sum: 16 bit signed coordinate plus 16 bit unsigned offset
  localparam int SUM_W   = 18;
  // non-negative sums never exceed 17 bits
  localparam int NUM_W   = 17;

  // divide by CELL_MM as multiply by reciprocal, exact for every NUM_W bit numerator
  localparam int RECIP_SH = $clog2((2 ** NUM_W) * CELL_MM);
  localparam int RECIP_M  = (2 ** RECIP_SH + CELL_MM - 1) / CELL_MM;
  localparam int RECIP_W  = $clog2(RECIP_M + 1);
  localparam int PROD_W   = (NUM_W + RECIP_W > RECIP_SH + IDX_W) ?
                            (NUM_W + RECIP_W) : (RECIP_SH + IDX_W);

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // configuration port
  localparam int NUM_REGS   = 8;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = $clog2(NUM_REGS * 4);
  localparam int REG_IDX_W  = $clog2(NUM_REGS);

  localparam int BLIND_W  = 12;
  localparam int BOX_W    = 15;
  localparam int SENSOR_W = 12;
  localparam int FLOORT_W = 10;
  localparam int ROBOT_W  = 12;
  localparam int ROBOTT_W = 10;
  localparam int OFFS_W   = 16;

  localparam logic [BLIND_W-1:0]  BLIND_RST  = BLIND_W'(200);
  localparam logic [BOX_W-1:0]    BOX_RST    = BOX_W'(3000);
  localparam logic [SENSOR_W-1:0] SENSOR_RST = SENSOR_W'(300);
  localparam logic [FLOORT_W-1:0] FLOORT_RST = FLOORT_W'(50);
  localparam logic [ROBOT_W-1:0]  ROBOT_RST  = ROBOT_W'(1000);
  localparam logic [ROBOTT_W-1:0] ROBOTT_RST = ROBOTT_W'(100);
  localparam logic [OFFS_W-1:0]   XOFF_RST   = OFFS_W'(3200);
  localparam logic [OFFS_W-1:0]   YOFF_RST   = OFFS_W'(3200);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BLIND  = 3'd0,
    REG_BOX    = 3'd1,
    REG_SENSOR = 3'd2,
    REG_FLOORT = 3'd3,
    REG_ROBOT  = 3'd4,
    REG_ROBOTT = 3'd5,
    REG_XOFF   = 3'd6,
    REG_YOFF   = 3'd7
  } reg_idx_e;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_READ   = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_BLIND    = 3'd1,
    ST_BOX      = 3'd2,
    ST_OFF_GRID = 3'd3,
    ST_READ     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    BAND_FALL     = 2'd0,
    BAND_FLOOR    = 2'd1,
    BAND_OBSTACLE = 2'd2,
    BAND_HIGH     = 2'd3
  } band_e;

  typedef struct packed {
    action_e                    action;
    logic signed [COORD_W-1:0]  x_mm;
    logic signed [COORD_W-1:0]  y_mm;
    logic signed [COORD_W-1:0]  z_mm;
    logic [RDIDX_W-1:0]         read_row;
    logic [RDIDX_W-1:0]         read_col;
  } item_t;

  typedef struct packed {
    status_e           status;
    logic [CELL_W-1:0] cell_flags;
    band_e             height_band;
  } result_t;

  typedef struct packed {
    logic [BLIND_W-1:0]  blind_radius_mm;
    logic [BOX_W-1:0]    box_limit_mm;
    logic [SENSOR_W-1:0] sensor_height_mm;
    logic [FLOORT_W-1:0] floor_tolerance_mm;
    logic [ROBOT_W-1:0]  robot_height_mm;
    logic [ROBOTT_W-1:0] robot_tolerance_mm;
    logic [OFFS_W-1:0]   x_offset_mm;
    logic [OFFS_W-1:0]   y_offset_mm;
  } cfg_t;

  // classified work item handed from front to back
  typedef struct packed {
    status_e           status;
    band_e             band;
    logic [ADDR_W-1:0] addr;
  } entry_t;

endpackage

`default_nettype wire

@@ hw/rtl/point_height_class_grid_binner_top.sv @@
// top level of the point height-class grid binner
// depends on phcgb_pkg, phcgb_regs, phcgb_front, phcgb_fifo, phcgb_back, phcgb_ram
//
// channel   direction  handshake                 payload
// --------  ---------  ------------------------  ---------------------------------
// item      in         start high, busy low      item_i (action, x/y/z, read row/col)
// result    out        done_o strobe, one cycle  result_o (status, flags, band)
// config    in         apb write, pready high    pwdata to register paddr[4:2]
//
// after reset the flag grid is cleared one cell per cycle, all GRID_ROWS*GRID_COLS
// cells (4096 at 64x64); busy stays high through it, config writes go through
// an item runs three front stages (classify, multiply by reciprocal of the cell
// size, address) into a four-entry queue; the back end reads the grid ram as it
// pops an insert or read and writes it in its rmw state, popping nothing meanwhile;
// a dropped point needs no ram, so that ram port pair sets the sustained rate
// busy rises when four transactions are in flight; results cannot be held off
`timescale 1ns / 1ps
`default_nettype none

module point_height_class_grid_binner_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // item channel
  input  wire logic                             start,
  output      logic                             busy,
  input  wire phcgb_pkg::item_t                 item_i,
  // result channel
  output      logic                             done_o,
  output      phcgb_pkg::result_t               result_o,
  // configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [phcgb_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [phcgb_pkg::APB_DATA_W-1:0] pwdata,
  output      logic [phcgb_pkg::APB_DATA_W-1:0] prdata,
  output      logic                             pready
);

  phcgb_pkg::cfg_t                  cfg;
  phcgb_pkg::entry_t                push_entry, head;
  logic                             accept, push, pop, empty, clr_done;
  logic [1:0]                       occ;
  logic [phcgb_pkg::Q_CNT_W-1:0]    q_count;
  logic [phcgb_pkg::Q_CNT_W:0]      in_flight;

  // credit: front stages plus queued entries never exceed the queue depth
  assign in_flight = (phcgb_pkg::Q_CNT_W+1)'(occ) + (phcgb_pkg::Q_CNT_W+1)'(q_count);
  assign busy      = !clr_done ||
                     (in_flight >= (phcgb_pkg::Q_CNT_W+1)'(phcgb_pkg::Q_DEPTH));
  assign accept    = start && !busy;

  // register file
  phcgb_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // filter, band and cell index
  phcgb_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .accept_i(accept),
    .item_i  (item_i),
    .push_o  (push),
    .entry_o (push_entry),
    .occ_o   (occ)
  );

  // decouples classification from grid access
  phcgb_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .pop_i  (pop),
    .head_o (head),
    .empty_o(empty),
    .count_o(q_count)
  );

  // grid update and result register
  phcgb_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .empty_i   (empty),
    .pop_o     (pop),
    .clr_done_o(clr_done),
    .done_o    (done_o),
    .result_o  (result_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/phcgb_ram.sv @@
// generic single write port ram with one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module phcgb_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/phcgb_regs.sv @@
// configuration register file with apb-style access
// depends on phcgb_pkg
`timescale 1ns / 1ps
`default_nettype none

module phcgb_regs (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [phcgb_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [phcgb_pkg::APB_DATA_W-1:0]     pwdata,
  output      logic [phcgb_pkg::APB_DATA_W-1:0]     prdata,
  output      logic                                 pready,
  output      phcgb_pkg::cfg_t                      cfg_o
);

  phcgb_pkg::cfg_t      cfg_q;
  phcgb_pkg::reg_idx_e  reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = phcgb_pkg::reg_idx_e'(paddr[phcgb_pkg::APB_ADDR_W-1:2]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blind_radius_mm    <= phcgb_pkg::BLIND_RST;
      cfg_q.box_limit_mm       <= phcgb_pkg::BOX_RST;
      cfg_q.sensor_height_mm   <= phcgb_pkg::SENSOR_RST;
      cfg_q.floor_tolerance_mm <= phcgb_pkg::FLOORT_RST;
      cfg_q.robot_height_mm    <= phcgb_pkg::ROBOT_RST;
      cfg_q.robot_tolerance_mm <= phcgb_pkg::ROBOTT_RST;
      cfg_q.x_offset_mm        <= phcgb_pkg::XOFF_RST;
      cfg_q.y_offset_mm        <= phcgb_pkg::YOFF_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        phcgb_pkg::REG_BLIND:
          cfg_q.blind_radius_mm <= pwdata[phcgb_pkg::BLIND_W-1:0];
        phcgb_pkg::REG_BOX:
          cfg_q.box_limit_mm <= pwdata[phcgb_pkg::BOX_W-1:0];
        phcgb_pkg::REG_SENSOR:
          cfg_q.sensor_height_mm <= pwdata[phcgb_pkg::SENSOR_W-1:0];
        phcgb_pkg::REG_FLOORT:
          cfg_q.floor_tolerance_mm <= pwdata[phcgb_pkg::FLOORT_W-1:0];
        phcgb_pkg::REG_ROBOT:
          cfg_q.robot_height_mm <= pwdata[phcgb_pkg::ROBOT_W-1:0];
        phcgb_pkg::REG_ROBOTT:
          cfg_q.robot_tolerance_mm <= pwdata[phcgb_pkg::ROBOTT_W-1:0];
        phcgb_pkg::REG_XOFF:
          cfg_q.x_offset_mm <= pwdata[phcgb_pkg::OFFS_W-1:0];
        phcgb_pkg::REG_YOFF:
          cfg_q.y_offset_mm <= pwdata[phcgb_pkg::OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      phcgb_pkg::REG_BLIND:  prdata = phcgb_pkg::APB_DATA_W'(cfg_q.blind_radius_mm);
      phcgb_pkg::REG_BOX:    prdata = phcgb_pkg::APB_DATA_W'(cfg_q.box_limit_mm);
      phcgb_pkg::REG_SENSOR: prdata = phcgb_pkg::APB_DATA_W'(cfg_q.sensor_height_mm);
      phcgb_pkg::REG_FLOORT: prdata = phcgb_pkg::APB_DATA_W'(cfg_q.floor_tolerance_mm);
      phcgb_pkg::REG_ROBOT:  prdata = phcgb_pkg::APB_DATA_W'(cfg_q.robot_height_mm);
      phcgb_pkg::REG_ROBOTT: prdata = phcgb_pkg::APB_DATA_W'(cfg_q.robot_tolerance_mm);
      phcgb_pkg::REG_XOFF:   prdata = phcgb_pkg::APB_DATA_W'(cfg_q.x_offset_mm);
      phcgb_pkg::REG_YOFF:   prdata = phcgb_pkg::APB_DATA_W'(cfg_q.y_offset_mm);
      default:               prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ hw/rtl/phcgb_front.sv @@
// front pipeline: filters points, sorts height band, finds the grid cell
// depends on phcgb_pkg
`timescale 1ns / 1ps
`default_nettype none

module phcgb_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire phcgb_pkg::cfg_t   cfg_i,
  input  wire logic              accept_i,
  input  wire phcgb_pkg::item_t  item_i,
  output      logic              push_o,
  output      phcgb_pkg::entry_t entry_o,
  output      logic [1:0]        occ_o
);

  typedef struct packed {
    phcgb_pkg::status_e                status;
    phcgb_pkg::band_e                  band;
    logic                              is_read;
    logic [phcgb_pkg::ROW_W-1:0]       rd_row;
    logic [phcgb_pkg::COL_W-1:0]       rd_col;
    logic [phcgb_pkg::NUM_W-1:0]       num_row;
    logic [phcgb_pkg::NUM_W-1:0]       num_col;
  } cls_t;

  typedef struct packed {
    phcgb_pkg::status_e                status;
    phcgb_pkg::band_e                  band;
    logic                              is_read;
    logic [phcgb_pkg::ROW_W-1:0]       rd_row;
    logic [phcgb_pkg::COL_W-1:0]       rd_col;
    logic [phcgb_pkg::PROD_W-1:0]      prod_row;
    logic [phcgb_pkg::PROD_W-1:0]      prod_col;
  } div_t;

  logic             s1_v_q, s2_v_q, s3_v_q;
  phcgb_pkg::item_t s1_q;
  cls_t             s2_d, s2_q;
  div_t             s3_d, s3_q;

  // stage one: classification
  logic [phcgb_pkg::COORD_W:0]          abs_x, abs_y;
  logic                                 blind_hit, box_out;
  logic signed [phcgb_pkg::SUM_W-1:0]   sx, sy, z_s;
  logic signed [phcgb_pkg::SUM_W-1:0]   fall_lim, floor_lim, top_lim;
  logic                                 col_off, row_off, rd_in;
  phcgb_pkg::band_e                     band;

  always_comb begin
    abs_x = s1_q.x_mm[phcgb_pkg::COORD_W-1] ?
            (phcgb_pkg::COORD_W+1)'(-(phcgb_pkg::SUM_W'(s1_q.x_mm))) :
            (phcgb_pkg::COORD_W+1)'(s1_q.x_mm);
    abs_y = s1_q.y_mm[phcgb_pkg::COORD_W-1] ?
            (phcgb_pkg::COORD_W+1)'(-(phcgb_pkg::SUM_W'(s1_q.y_mm))) :
            (phcgb_pkg::COORD_W+1)'(s1_q.y_mm);

    blind_hit = (abs_x < (phcgb_pkg::COORD_W+1)'(cfg_i.blind_radius_mm)) &&
                (abs_y < (phcgb_pkg::COORD_W+1)'(cfg_i.blind_radius_mm));
    box_out   = !((abs_x < (phcgb_pkg::COORD_W+1)'(cfg_i.box_limit_mm)) &&
                  (abs_y < (phcgb_pkg::COORD_W+1)'(cfg_i.box_limit_mm)));

    sx = phcgb_pkg::SUM_W'(s1_q.x_mm) +
         $signed(phcgb_pkg::SUM_W'(cfg_i.x_offset_mm));
    sy = $signed(phcgb_pkg::SUM_W'(cfg_i.y_offset_mm)) -
         phcgb_pkg::SUM_W'(s1_q.y_mm);

    // sums from -CELL_MM+1 to -1 truncate to index zero
    col_off = (int'(sx) <= -phcgb_pkg::CELL_MM) || (int'(sx) >= phcgb_pkg::COL_SPAN);
    row_off = (int'(sy) <= -phcgb_pkg::CELL_MM) || (int'(sy) >= phcgb_pkg::ROW_SPAN);

    z_s       = phcgb_pkg::SUM_W'(s1_q.z_mm);
    fall_lim  = -$signed(phcgb_pkg::SUM_W'(cfg_i.sensor_height_mm) +
                         phcgb_pkg::SUM_W'(cfg_i.floor_tolerance_mm));
    floor_lim = $signed(phcgb_pkg::SUM_W'(cfg_i.floor_tolerance_mm)) -
                $signed(phcgb_pkg::SUM_W'(cfg_i.sensor_height_mm));
    top_lim   = $signed(phcgb_pkg::SUM_W'(cfg_i.robot_height_mm) +
                        phcgb_pkg::SUM_W'(cfg_i.robot_tolerance_mm));

    if (z_s <= fall_lim) begin
      band = phcgb_pkg::BAND_FALL;
    end else if (z_s <= floor_lim) begin
      band = phcgb_pkg::BAND_FLOOR;
    end else if (z_s <= top_lim) begin
      band = phcgb_pkg::BAND_OBSTACLE;
    end else begin
      band = phcgb_pkg::BAND_HIGH;
    end

    rd_in = (32'(s1_q.read_row) < 32'(phcgb_pkg::GRID_ROWS)) &&
            (32'(s1_q.read_col) < 32'(phcgb_pkg::GRID_COLS));

    s2_d.is_read = (s1_q.action == phcgb_pkg::ACT_READ);
    s2_d.rd_row  = phcgb_pkg::ROW_W'(s1_q.read_row);
    s2_d.rd_col  = phcgb_pkg::COL_W'(s1_q.read_col);
    s2_d.num_col = sx[phcgb_pkg::SUM_W-1] ? '0 : sx[phcgb_pkg::NUM_W-1:0];
    s2_d.num_row = sy[phcgb_pkg::SUM_W-1] ? '0 : sy[phcgb_pkg::NUM_W-1:0];
    s2_d.band    = phcgb_pkg::BAND_FALL;

    if (s1_q.action == phcgb_pkg::ACT_READ) begin
      s2_d.status = rd_in ? phcgb_pkg::ST_READ : phcgb_pkg::ST_OFF_GRID;
    end else if (blind_hit) begin
      s2_d.status = phcgb_pkg::ST_BLIND;
    end else if (box_out) begin
      s2_d.status = phcgb_pkg::ST_BOX;
    end else begin
      s2_d.band   = band;
      s2_d.status = (col_off || row_off) ? phcgb_pkg::ST_OFF_GRID : phcgb_pkg::ST_STORED;
    end
  end

  // stage two: reciprocal multiply for the divide by cell size
  always_comb begin
    s3_d.status   = s2_q.status;
    s3_d.band     = s2_q.band;
    s3_d.is_read  = s2_q.is_read;
    s3_d.rd_row   = s2_q.rd_row;
    s3_d.rd_col   = s2_q.rd_col;
    s3_d.prod_row = phcgb_pkg::PROD_W'(s2_q.num_row) *
                    phcgb_pkg::PROD_W'(phcgb_pkg::RECIP_M);
    s3_d.prod_col = phcgb_pkg::PROD_W'(s2_q.num_col) *
                    phcgb_pkg::PROD_W'(phcgb_pkg::RECIP_M);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_q <= item_i;
    end
    s2_q <= s2_d;
    s3_q <= s3_d;
  end

  // stage three: form the cell address and push
  logic [phcgb_pkg::ROW_W-1:0] row;
  logic [phcgb_pkg::COL_W-1:0] col;

  always_comb begin
    row = s3_q.is_read ? s3_q.rd_row : s3_q.prod_row[phcgb_pkg::RECIP_SH +: phcgb_pkg::ROW_W];
    col = s3_q.is_read ? s3_q.rd_col : s3_q.prod_col[phcgb_pkg::RECIP_SH +: phcgb_pkg::COL_W];
    entry_o.status = s3_q.status;
    entry_o.band   = s3_q.band;
    entry_o.addr   = phcgb_pkg::ADDR_W'(phcgb_pkg::ADDR_W'(row) *
                                        phcgb_pkg::ADDR_W'(phcgb_pkg::GRID_COLS)) +
                     phcgb_pkg::ADDR_W'(col);
  end

  assign push_o = s3_v_q;
  assign occ_o  = 2'(s1_v_q) + 2'(s2_v_q) + 2'(s3_v_q);

endmodule

`default_nettype wire

@@ hw/rtl/phcgb_fifo.sv @@
// short register queue of classified transactions between front and back
// depends on phcgb_pkg
`timescale 1ns / 1ps
`default_nettype none

module phcgb_fifo (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  input  wire phcgb_pkg::entry_t             entry_i,
  input  wire logic                          pop_i,
  output      phcgb_pkg::entry_t             head_o,
  output      logic                          empty_o,
  output      logic [phcgb_pkg::Q_CNT_W-1:0] count_o
);

  phcgb_pkg::entry_t                 slot_q [phcgb_pkg::Q_DEPTH];
  logic [phcgb_pkg::Q_PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [phcgb_pkg::Q_CNT_W-1:0]     count_q;

  // push never meets a full queue: the top level limits transactions in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + phcgb_pkg::Q_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + phcgb_pkg::Q_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + phcgb_pkg::Q_CNT_W'(1);
      end else if (!push_i && pop_i) begin
        count_q <= count_q - phcgb_pkg::Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  assign head_o  = slot_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

endmodule

`default_nettype wire

@@ hw/rtl/phcgb_back.sv @@
// back end: grid clearing pass, read-modify-write of the flag grid, result register
// depends on phcgb_pkg and phcgb_ram
`timescale 1ns / 1ps
`default_nettype none

module phcgb_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire phcgb_pkg::entry_t  head_i,
  input  wire logic               empty_i,
  output      logic               pop_o,
  output      logic               clr_done_o,
  output      logic               done_o,
  output      phcgb_pkg::result_t result_o
);

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_RMW
  } back_state_e;

  back_state_e                    state_q;
  logic [phcgb_pkg::ADDR_W-1:0]   clr_addr_q;
  phcgb_pkg::entry_t              cur_q;
  logic                           done_q;
  phcgb_pkg::result_t             result_q;

  logic                           need_mem;
  logic                           ram_we;
  logic [phcgb_pkg::ADDR_W-1:0]   ram_waddr;
  logic [phcgb_pkg::CELL_W-1:0]   ram_wdata, ram_rdata, new_flags;

  assign need_mem = (head_i.status == phcgb_pkg::ST_STORED) ||
                    (head_i.status == phcgb_pkg::ST_READ);
  assign pop_o    = (state_q == BK_IDLE) && !empty_i;

  // insert sets the band flag, read clears the cell
  assign new_flags = (cur_q.status == phcgb_pkg::ST_STORED) ?
                     (ram_rdata | (phcgb_pkg::CELL_W'(1) << cur_q.band)) : '0;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_q.addr;
    ram_wdata = new_flags;
    unique case (state_q)
      BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_q;
        ram_wdata = '0;
      end
      BK_RMW: begin
        ram_we = 1'b1;
      end
      default: ;
    endcase
  end

  phcgb_ram #(
    .WIDTH(phcgb_pkg::CELL_W),
    .DEPTH(phcgb_pkg::CELLS)
  ) u_grid (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(head_i.addr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_CLEAR;
      clr_addr_q <= '0;
      done_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        BK_CLEAR: begin
          clr_addr_q <= clr_addr_q + phcgb_pkg::ADDR_W'(1);
          if (clr_addr_q == phcgb_pkg::ADDR_W'(phcgb_pkg::CELLS - 1)) begin
            state_q <= BK_IDLE;
          end
        end
        BK_IDLE: begin
          if (!empty_i) begin
            cur_q <= head_i;
            if (need_mem) begin
              state_q <= BK_RMW;
            end else begin
              done_q                  <= 1'b1;
              result_q.status         <= head_i.status;
              result_q.cell_flags     <= '0;
              result_q.height_band    <= head_i.band;
            end
          end
        end
        BK_RMW: begin
          done_q               <= 1'b1;
          result_q.status      <= cur_q.status;
          result_q.height_band <= cur_q.band;
          result_q.cell_flags  <= (cur_q.status == phcgb_pkg::ST_STORED) ?
                                  new_flags : ram_rdata;
          state_q              <= BK_IDLE;
        end
        default: state_q <= BK_IDLE;
      endcase
    end
  end

  assign clr_done_o = (state_q != BK_CLEAR);
  assign done_o     = done_q;
  assign result_o   = result_q;

endmodule

`default_nettype wire

@@ verif/point_height_class_grid_binner_top_tb.sv @@
// self-checking testbench for point_height_class_grid_binner_top: directed and random lidar
// points and cell reads under several register settings, checked against an in-bench model
// depends on phcgb_pkg and the rtl of point_height_class_grid_binner_top
`timescale 1ns / 1ps

module point_height_class_grid_binner_top_tb;
  import phcgb_pkg::*;

  // a quiet stretch longer than this ends the run; covers the grid clearing pass after reset
  localparam int WATCHDOG_LIMIT = 20000;
  // idle cycles after the last result before config writes and before the verdict
  localparam int SETTLE_CYCLES  = 12;
  localparam int PHASE_ITEMS    = 64;
  localparam int HOT_DEPTH      = 16;

  logic                  clk_i   = 1'b0;
  logic                  rst_ni  = 1'b0;
  logic                  start   = 1'b0;
  logic                  busy;
  item_t                 item_i  = '0;
  logic                  done_o;
  result_t               result_o;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  point_height_class_grid_binner_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // model state: register copy set at register writes, flag grid updated only at accepted transactions
  // ---------------------------------------------------------------------------
  cfg_t        cfg_model;
  logic [3:0]  grid_model [CELLS];
  item_t       point_queue [$];       // items waiting to be driven
  result_t     predicted_results [$]; // results owed by the dut, oldest first
  int          hot_cells [$];         // recently hit cells, so reads find flags set
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          center_x, center_y;    // cluster center of the current phase

  // append one item to the pending queue
  function automatic void enqueue(input item_t it);
    point_queue = {point_queue, it};
  endfunction

  // cell position of a point under the current offsets; division truncates toward zero
  function automatic void locate_cell(input int x, input int y, output int row, output int col);
    col = (x + int'(cfg_model.x_offset_mm)) / CELL_MM;
    row = (-y + int'(cfg_model.y_offset_mm)) / CELL_MM;
  endfunction

  // expected result of one accepted transaction, with its effect on the grid
  function automatic result_t bin_point(input item_t it);
    result_t r;
    int x, y, z, ax, ay, row, col, sh, ft, idx;
    r.status      = ST_STORED;
    r.cell_flags  = '0;
    r.height_band = BAND_FALL;
    if (it.action == ACT_READ) begin
      if (int'(it.read_row) < GRID_ROWS && int'(it.read_col) < GRID_COLS) begin
        idx = int'(it.read_row) * GRID_COLS + int'(it.read_col);
        r.status        = ST_READ;
        r.cell_flags    = grid_model[idx];
        grid_model[idx] = '0;
      end else begin
        r.status = ST_OFF_GRID;
      end
      return r;
    end
    x  = $signed(it.x_mm);
    y  = $signed(it.y_mm);
    z  = $signed(it.z_mm);
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    // blind square wins over the box limit
    if (ax < int'(cfg_model.blind_radius_mm) && ay < int'(cfg_model.blind_radius_mm)) begin
      r.status = ST_BLIND;
      return r;
    end
    if (!(ax < int'(cfg_model.box_limit_mm) && ay < int'(cfg_model.box_limit_mm))) begin
      r.status = ST_BOX;
      return r;
    end
    sh = int'(cfg_model.sensor_height_mm);
    ft = int'(cfg_model.floor_tolerance_mm);
    if (z <= -(sh + ft))
      r.height_band = BAND_FALL;
    else if (z <= -(sh - ft))
      r.height_band = BAND_FLOOR;
    else if (z <= int'(cfg_model.robot_height_mm) + int'(cfg_model.robot_tolerance_mm))
      r.height_band = BAND_OBSTACLE;
    else
      r.height_band = BAND_HIGH;
    locate_cell(x, y, row, col);
    if (row < 0 || row >= GRID_ROWS || col < 0 || col >= GRID_COLS) begin
      // band is still reported, nothing is stored
      r.status = ST_OFF_GRID;
    end else begin
      idx             = row * GRID_COLS + col;
      grid_model[idx] = grid_model[idx] | (4'b0001 << r.height_band);
      r.cell_flags    = grid_model[idx];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // item driver: presents queued items, random gaps with bursts of back-to-back items
  // ---------------------------------------------------------------------------
  int idle_left = 0;
  bit burst     = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start     <= 1'b0;
      item_i    <= '0;
      idle_left <= 0;
    end else begin
      // transaction accepted at this edge: predict from the item that was on the port
      if (start && !busy)
        predicted_results = {predicted_results, bin_point(item_i)};
      // port is free when nothing is offered or the offer was just taken
      if (!start || !busy) begin
        if (idle_left > 0) begin
          idle_left <= idle_left - 1;
          start     <= 1'b0;
        end else if (point_queue.size() > 0) begin
          item_i <= point_queue.pop_front();
          start  <= 1'b1;
          // gap before the next item; bursts leave no gaps at all
          if ($urandom_range(0, 29) == 0)
            burst = !burst;
          idle_left <= burst ? 0 : $urandom_range(0, 19);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: every strobe must match the oldest prediction field by field
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && done_o) begin
      if (predicted_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d flags %0d band %0d",
                 $time, result_o.status, result_o.cell_flags, result_o.height_band);
        mismatches++;
      end else begin
        exp_r = predicted_results.pop_front();
        if (result_o.status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, result_o.status);
          mismatches++;
        end
        if (result_o.cell_flags !== exp_r.cell_flags) begin
          $display("%0t: cell_flags expected %0d actual %0d",
                   $time, exp_r.cell_flags, result_o.cell_flags);
          mismatches++;
        end
        if (result_o.height_band !== exp_r.height_band) begin
          $display("%0t: height_band expected %0d actual %0d",
                   $time, exp_r.height_band, result_o.height_band);
          mismatches++;
        end
      end
    end
  end

  // watchdog: any item, result or register transaction counts as progress
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("point_height_class_grid_binner_top_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // register access
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] reg_field(input cfg_t c, input reg_idx_e r);
    case (r)
      REG_BLIND:  return 32'(c.blind_radius_mm);
      REG_BOX:    return 32'(c.box_limit_mm);
      REG_SENSOR: return 32'(c.sensor_height_mm);
      REG_FLOORT: return 32'(c.floor_tolerance_mm);
      REG_ROBOT:  return 32'(c.robot_height_mm);
      REG_ROBOTT: return 32'(c.robot_tolerance_mm);
      REG_XOFF:   return 32'(c.x_offset_mm);
      default:    return 32'(c.y_offset_mm);
    endcase
  endfunction

  // write one register, then read it back
  task automatic write_reg(input reg_idx_e r, input logic [31:0] value);
    logic [31:0] readback;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({r, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // write transaction completes at this edge
    case (r)
      REG_BLIND:  cfg_model.blind_radius_mm    = value[BLIND_W-1:0];
      REG_BOX:    cfg_model.box_limit_mm       = value[BOX_W-1:0];
      REG_SENSOR: cfg_model.sensor_height_mm   = value[SENSOR_W-1:0];
      REG_FLOORT: cfg_model.floor_tolerance_mm = value[FLOORT_W-1:0];
      REG_ROBOT:  cfg_model.robot_height_mm    = value[ROBOT_W-1:0];
      REG_ROBOTT: cfg_model.robot_tolerance_mm = value[ROBOTT_W-1:0];
      REG_XOFF:   cfg_model.x_offset_mm        = value[OFFS_W-1:0];
      default:    cfg_model.y_offset_mm        = value[OFFS_W-1:0];
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== reg_field(cfg_model, r)) begin
      $display("%0t: register %0d readback expected %0d actual %0d",
               $time, r, reg_field(cfg_model, r), readback);
      mismatches++;
    end
  endtask

  task automatic program_all(input cfg_t c);
    for (int i = 0; i < NUM_REGS; i++)
      write_reg(reg_idx_e'(i), reg_field(c, reg_idx_e'(i)));
  endtask

  // sender holds off until every queued item is taken and every result is back
  task automatic drain();
    while (point_queue.size() != 0 || start || predicted_results.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic item_t mk_insert(input int x, input int y, input int z);
    item_t it;
    it.action   = ACT_INSERT;
    it.x_mm     = 16'(x);
    it.y_mm     = 16'(y);
    it.z_mm     = 16'(z);
    it.read_row = RDIDX_W'($urandom);
    it.read_col = RDIDX_W'($urandom);
    return it;
  endfunction

  function automatic item_t mk_read(input int row, input int col);
    item_t it;
    it.action   = ACT_READ;
    it.x_mm     = 16'($urandom);
    it.y_mm     = 16'($urandom);
    it.z_mm     = 16'($urandom);
    it.read_row = RDIDX_W'(row);
    it.read_col = RDIDX_W'(col);
    return it;
  endfunction

  // coordinate: full range, inside the box, near the phase cluster, or on a limit edge
  function automatic int pick_coord(input int center);
    int box   = int'(cfg_model.box_limit_mm);
    int blind = int'(cfg_model.blind_radius_mm);
    case ($urandom_range(0, 4))
      0:       return $signed(16'($urandom));
      1:       return $urandom_range(0, 2 * box) - box;
      2:       return center + $urandom_range(0, 300) - 150;
      3:       return ($urandom_range(0, 1) ? blind : -blind) + $urandom_range(0, 2) - 1;
      default: return ($urandom_range(0, 1) ? box : -box) + $urandom_range(0, 2) - 1;
    endcase
  endfunction

  // height: full range, a band edge give or take one, or a span reaching past the lowest and top edges
  function automatic int pick_height();
    int sh  = int'(cfg_model.sensor_height_mm);
    int ft  = int'(cfg_model.floor_tolerance_mm);
    int top = int'(cfg_model.robot_height_mm) + int'(cfg_model.robot_tolerance_mm);
    int d   = $urandom_range(0, 2) - 1;
    case ($urandom_range(0, 4))
      0:       return $signed(16'($urandom));
      1:       return -(sh + ft) + d;
      2:       return -(sh - ft) + d;
      3:       return top + d;
      default: return $urandom_range(0, top + sh + ft + 1000) - (sh + ft + 500);
    endcase
  endfunction

  function automatic item_t random_item();
    item_t it;
    int row, col, idx;
    // about one in four is a read, mostly of a cell that was hit recently
    if ($urandom_range(0, 3) == 0) begin
      if (hot_cells.size() > 0 && $urandom_range(0, 2) != 0) begin
        idx = hot_cells[$urandom_range(0, hot_cells.size() - 1)];
        return mk_read(idx / GRID_COLS, idx % GRID_COLS);
      end
      return mk_read($urandom_range(0, 63), $urandom_range(0, 63));
    end
    it = mk_insert(pick_coord(center_x), pick_coord(center_y), pick_height());
    locate_cell($signed(it.x_mm), $signed(it.y_mm), row, col);
    if (row >= 0 && row < GRID_ROWS && col >= 0 && col < GRID_COLS) begin
      hot_cells = {hot_cells, row * GRID_COLS + col};
      if (hot_cells.size() > HOT_DEPTH)
        void'(hot_cells.pop_front());
    end
    return it;
  endfunction

  task automatic random_phase(input int n);
    // cluster center chosen so that most clustered points land on the grid
    center_x = $urandom_range(0, COL_SPAN - 1) - int'(cfg_model.x_offset_mm);
    center_y = int'(cfg_model.y_offset_mm) - $urandom_range(0, ROW_SPAN - 1);
    hot_cells.delete();
    repeat (n) enqueue(random_item());
    drain();
  endtask

  function automatic cfg_t random_setting();
    cfg_t c;
    c.blind_radius_mm    = BLIND_W'($urandom_range(0, 1000));
    c.box_limit_mm       = BOX_W'($urandom_range(300, 6000));
    c.sensor_height_mm   = SENSOR_W'($urandom_range(0, 4000));
    c.floor_tolerance_mm = FLOORT_W'($urandom_range(0, 1000));
    c.robot_height_mm    = ROBOT_W'($urandom_range(0, 4000));
    c.robot_tolerance_mm = ROBOTT_W'($urandom_range(0, 1000));
    c.x_offset_mm        = OFFS_W'($urandom_range(0, 6500));
    c.y_offset_mm        = OFFS_W'($urandom_range(0, 6500));
    return c;
  endfunction

  initial begin
    cfg_t setting;
    foreach (grid_model[i]) grid_model[i] = '0;
    cfg_model = '{blind_radius_mm: BLIND_RST, box_limit_mm: BOX_RST,
                  sensor_height_mm: SENSOR_RST, floor_tolerance_mm: FLOORT_RST,
                  robot_height_mm: ROBOT_RST, robot_tolerance_mm: ROBOTT_RST,
                  x_offset_mm: XOFF_RST, y_offset_mm: YOFF_RST};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset settings: blind square edges, box edges, field extremes
    enqueue(mk_insert(0, 0, 0));
    enqueue(mk_insert(199, -199, 0));
    enqueue(mk_insert(200, 0, 0));
    enqueue(mk_insert(2999, -2999, 32767));
    enqueue(mk_insert(3000, 0, 0));
    enqueue(mk_insert(0, -3000, 0));
    enqueue(mk_insert(-32768, -32768, -32768));
    enqueue(mk_insert(32767, 32767, 32767));
    // every band edge into one cell (row 27, col 37), then read it twice
    enqueue(mk_insert(500, 500, -350));
    enqueue(mk_insert(500, 500, -349));
    enqueue(mk_insert(500, 500, -250));
    enqueue(mk_insert(500, 500, -249));
    enqueue(mk_insert(500, 500, 1100));
    enqueue(mk_insert(500, 500, 1101));
    enqueue(mk_read(27, 37));
    enqueue(mk_read(27, 37));
    drain();

    // directed, zero offsets and wide box: small negative sums truncate to row or column
    // zero, one cell further is off the grid, and the far grid edge
    setting = '{blind_radius_mm: 12'd0, box_limit_mm: 15'd10000,
                sensor_height_mm: SENSOR_RST, floor_tolerance_mm: FLOORT_RST,
                robot_height_mm: ROBOT_RST, robot_tolerance_mm: ROBOTT_RST,
                x_offset_mm: 16'd0, y_offset_mm: 16'd0};
    program_all(setting);
    enqueue(mk_insert(-50, 50, -32768));
    enqueue(mk_insert(-150, 0, 0));
    enqueue(mk_insert(0, 150, 0));
    enqueue(mk_insert(6399, -6299, 0));
    enqueue(mk_insert(6400, 0, 0));
    enqueue(mk_insert(0, -6400, 0));
    enqueue(mk_read(0, 0));
    enqueue(mk_read(63, 63));
    drain();

    // random phases: all registers lowest, then high (box and offsets at max), then mixed
    program_all('0);
    random_phase(PHASE_ITEMS);
    setting = '{blind_radius_mm: 12'd3000, box_limit_mm: 15'd32767,
                sensor_height_mm: 12'd4000, floor_tolerance_mm: 10'd1000,
                robot_height_mm: 12'd4000, robot_tolerance_mm: 10'd1000,
                x_offset_mm: 16'hffff, y_offset_mm: 16'hffff};
    program_all(setting);
    random_phase(PHASE_ITEMS);
    repeat (5) begin
      program_all(random_setting());
      random_phase(PHASE_ITEMS);
    end

    // drain() has already let the pipeline settle with nothing outstanding
    if (mismatches == 0)
      $display("point_height_class_grid_binner_top_tb passed");
    else
      $display("point_height_class_grid_binner_top_tb failed");
    $finish;
  end

endmodule
